[src/sbx_pkg.sv]
package sbx_pkg;

	// Field widths
	localparam int GENE_W     = 32;
	localparam int SAMPLE_BITS = 24;
	localparam int CFG_W      = 17;
	localparam int LOG_FRAC   = 24;

	// Derived widths
	localparam int P_W    = $clog2(SAMPLE_BITS);
	localparam int MT_W   = 31;
	localparam int LMAG_W = P_W + LOG_FRAC;
	localparam int PROD_W = LMAG_W + CFG_W;
	localparam int MAG_W  = PROD_W - 15;
	localparam int K_W    = MAG_W - LOG_FRAC;
	localparam int SH_W   = K_W + 1;
	localparam int D_W    = GENE_W + 1;
	localparam int H_W    = 35;
	localparam int C_W    = 37;

	localparam logic [CFG_W-1:0] SPREAD_RESET = CFG_W'(3121);

	// Side data that travels along the whole pipe
	typedef struct packed {
		logic                 last;
		logic signed [D_W-1:0] sum;
		logic                 d_neg;
		logic [GENE_W-1:0]    ad;
		logic                 neg;
		logic                 zero;
		logic [P_W-1:0]       p;
		logic [LOG_FRAC-1:0]  earg;
		logic [SH_W-1:0]      shamt;
		logic                 big;
	} side_t;

	// Integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = x;
		res = '0;
		bt  = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(2^-(j+1)) in Q1.30, by repeated roots of 2
	function automatic logic [MT_W-1:0] root_val(input int j);
		logic [63:0] r;
		r = 64'h1 << 31;
		for (int i = 0; i <= j; i++) begin
			r = isqrt64(r << 30);
		end
		return r[MT_W-1:0];
	endfunction

endpackage

[src/sbx_crossover_gene_unit.sv]
// channel   direction  handshake             words
// in        sink       in_valid / in_ready   father_gene, mother_gene, uniform_sample, last_gene
// out       source     out_valid / out_ready son_gene, daughter_gene, child_saturated, last_out
// cfg       sink       cfg_wr_en             cfg_wr_data (spread exponent, Q1.16)
//
// One word enters per cycle while in_ready is high; most of the pipe is the 24 squaring
// stages of the logarithm and the 24 root-multiply stages of the power.
// arst_n clears the valid bits, the skid flag and the exponent (3121).
// A stall holds the whole pipe once the output skid stage is full; the
// skid stage lets the input stay ready for the cycle in which output stops.
module sbx_crossover_gene_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sbx_pkg::GENE_W-1:0]   father_gene,
	input  logic signed [sbx_pkg::GENE_W-1:0]   mother_gene,
	input  logic [sbx_pkg::SAMPLE_BITS-1:0]     uniform_sample,
	input  logic                                last_gene,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sbx_pkg::GENE_W-1:0]   son_gene,
	output logic signed [sbx_pkg::GENE_W-1:0]   daughter_gene,
	output logic                                child_saturated,
	output logic                                last_out,
	input  logic                                cfg_wr_en,
	input  logic [sbx_pkg::CFG_W-1:0]           cfg_wr_data
);
	import sbx_pkg::*;

	localparam int LOG_FIRST = 4;
	localparam int ST_LMAG   = LOG_FIRST + LOG_FRAC;
	localparam int ST_MUL    = ST_LMAG + 1;
	localparam int ST_DEC    = ST_MUL + 1;
	localparam int ST_BETA   = ST_DEC + LOG_FRAC + 1;
	localparam int ST_PROD   = ST_BETA + 1;
	localparam int ST_H      = ST_PROD + 1;

	localparam logic [LMAG_W-1:0]   LOG_TOP  = LMAG_W'(SAMPLE_BITS - 1) << LOG_FRAC;
	localparam logic [MT_W-1:0]     ONE_Q30  = MT_W'(1) << 30;
	localparam logic [H_W-1:0]      H_MAX    = H_W'(1) << 34;
	localparam logic signed [C_W-1:0] C_MAX  = C_W'(33'sh0_7FFF_FFFF);
	localparam logic signed [C_W-1:0] C_MIN  = -(C_W'(1) << 31);

	logic [CFG_W-1:0] spread_q;
	logic             en;
	logic             skid_q;

	side_t sd_s   [1:ST_H];
	side_t sd_nxt [1:ST_H];
	logic  vld_s  [1:ST_H];

	logic [SAMPLE_BITS-1:0] n_s1, n_s2;
	logic [P_W-1:0]         lzc_p;
	logic [MT_W-1:0]        lg_mt_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0]    lg_fr_s [0:LOG_FRAC];
	logic [LMAG_W-1:0]      lmag_s;
	logic [PROD_W-1:0]      prod_s;
	logic [MT_W-1:0]        ex_acc_s [0:LOG_FRAC-1];
	logic [63:0]            beta_s;
	logic [63:0]            xp_s, yp_s;
	logic [H_W-1:0]         h_s;

	// Exponent register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spread_q <= SPREAD_RESET;
		end else if (cfg_wr_en) begin
			spread_q <= cfg_wr_data;
		end
	end

	assign en       = !skid_q;
	assign in_ready = en;

	// Side data: entry, leading-one position and exponent decode
	logic signed [D_W-1:0] in_d;
	logic [MAG_W-1:0]      mag;
	logic [K_W-1:0]        mag_k;
	logic [LOG_FRAC-1:0]   mag_fr;
	logic [LOG_FRAC:0]     fr_inv;

	always_comb begin
		in_d   = {father_gene[GENE_W-1], father_gene} - {mother_gene[GENE_W-1], mother_gene};
		lzc_p  = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (n_s1[i]) lzc_p = P_W'(i);
		end
		mag    = MAG_W'((prod_s + PROD_W'(32768)) >> 16);
		mag_k  = mag[MAG_W-1:LOG_FRAC];
		mag_fr = mag[LOG_FRAC-1:0];
		fr_inv = (LOG_FRAC+1)'(1) << LOG_FRAC;
		fr_inv = fr_inv - {1'b0, mag_fr};

		for (int i = 2; i <= ST_H; i++) sd_nxt[i] = sd_s[i-1];

		sd_nxt[1]       = '0;
		sd_nxt[1].last  = last_gene;
		sd_nxt[1].sum   = {father_gene[GENE_W-1], father_gene}
				+ {mother_gene[GENE_W-1], mother_gene};
		sd_nxt[1].d_neg = in_d[D_W-1];
		sd_nxt[1].ad    = in_d[D_W-1] ? GENE_W'(-in_d) : in_d[GENE_W-1:0];
		sd_nxt[1].neg   = !uniform_sample[SAMPLE_BITS-1];
		sd_nxt[1].zero  = (uniform_sample == '0);

		sd_nxt[2].p = lzc_p;

		sd_nxt[ST_DEC].big   = !sd_s[ST_DEC-1].neg && (mag_k >= K_W'(33));
		if (!sd_s[ST_DEC-1].neg || mag_fr == '0) begin
			sd_nxt[ST_DEC].earg  = sd_s[ST_DEC-1].neg ? '0 : mag_fr;
			sd_nxt[ST_DEC].shamt = {1'b0, mag_k};
		end else begin
			sd_nxt[ST_DEC].earg  = fr_inv[LOG_FRAC-1:0];
			sd_nxt[ST_DEC].shamt = {1'b0, mag_k} + SH_W'(1);
		end
	end

	// Advance valid bits and side data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ST_H; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= ST_H; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i <= ST_H; i++) sd_s[i] <= sd_nxt[i];
		end
	end

	// Log argument, leading one, normalise to Q1.30
	logic [SAMPLE_BITS:0] n_full;
	logic [P_W-1:0]       norm_sh;

	always_comb begin
		n_full  = (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
		n_full  = n_full - {1'b0, uniform_sample};
		norm_sh = P_W'(30) - sd_s[2].p;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1       <= uniform_sample[SAMPLE_BITS-1] ? n_full[SAMPLE_BITS-1:0]
					: uniform_sample;
			n_s2       <= n_s1;
			lg_mt_s[0] <= {{(MT_W-SAMPLE_BITS){1'b0}}, n_s2} << norm_sh;
			lg_fr_s[0] <= '0;
		end
	end

	// Logarithm fraction: one squaring per stage
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
		logic [2*MT_W-1:0] sq;
		logic [MT_W:0]     sq_hi;

		always_comb begin
			sq    = {{MT_W{1'b0}}, lg_mt_s[j]} * {{MT_W{1'b0}}, lg_mt_s[j]};
			sq_hi = sq[2*MT_W-1:30];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lg_mt_s[j+1] <= sq_hi[MT_W] ? sq_hi[MT_W:1] : sq_hi[MT_W-1:0];
				lg_fr_s[j+1] <= {lg_fr_s[j][LOG_FRAC-2:0], sq_hi[MT_W]};
			end
		end
	end

	// Log magnitude, times exponent
	always_ff @(posedge clk) begin
		if (en) begin
			lmag_s <= LOG_TOP - {sd_s[ST_LMAG-1].p, lg_fr_s[LOG_FRAC]};
			prod_s <= PROD_W'(lmag_s) * PROD_W'(spread_q);
		end
	end

	// Power of two: one root multiply per fraction bit, top bit first
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_exp
		localparam logic [MT_W-1:0] ROOT = root_val(j);
		logic [MT_W-1:0]   acc_in;
		logic [2*MT_W-1:0] pr;

		always_comb begin
			acc_in = (j == 0) ? ONE_Q30 : ex_acc_s[(j == 0) ? 0 : j-1];
			pr     = {{MT_W{1'b0}}, acc_in} * {{MT_W{1'b0}}, ROOT};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ex_acc_s[j] <= sd_s[ST_DEC+j].earg[LOG_FRAC-1-j] ? pr[MT_W+29:30] : acc_in;
			end
		end
	end

	// Spread factor in Q.30, then the two partial products
	side_t            sd_b;
	logic [MT_W-1:0]  acc_f;
	logic [63:0]      beta_nxt;

	always_comb begin
		sd_b  = sd_s[ST_BETA-1];
		acc_f = ex_acc_s[LOG_FRAC-1];
		if (spread_q == '0) begin
			beta_nxt = 64'(ONE_Q30);
		end else if (sd_b.zero) begin
			beta_nxt = '0;
		end else if (!sd_b.neg) begin
			beta_nxt = sd_b.big ? (64'h1 << 63) : (64'(acc_f) << sd_b.shamt[5:0]);
		end else if (sd_b.shamt >= SH_W'(MT_W)) begin
			beta_nxt = '0;
		end else begin
			beta_nxt = 64'(acc_f) >> sd_b.shamt[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beta_s <= beta_nxt;
			xp_s   <= {32'b0, beta_s[63:32]} * {32'b0, sd_s[ST_PROD-1].ad};
			yp_s   <= {32'b0, beta_s[31:0]} * {32'b0, sd_s[ST_PROD-1].ad};
		end
	end

	// Rounded product, held at 2^34
	logic [64:0]    y_rnd;
	logic [H_W-1:0] r_rnd;
	logic [H_W+2:0] h_sum;
	logic [H_W-1:0] h_nxt;

	always_comb begin
		y_rnd = {1'b0, yp_s} + 65'(1 << 29);
		r_rnd = y_rnd[64:30];
		h_sum = {xp_s[H_W-1:0], 2'b00} + (H_W+3)'(r_rnd);
		if (xp_s > 64'(H_MAX) || h_sum > (H_W+3)'(H_MAX)) begin
			h_nxt = H_MAX;
		end else begin
			h_nxt = h_sum[H_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s <= h_nxt;
		end
	end

	// Children: halve with floor, then saturate
	side_t                 sd_c;
	logic signed [C_W-1:0] sh_c, son_w, dau_w;
	logic signed [GENE_W-1:0] son_c, dau_c;
	logic                  sat_c;

	always_comb begin
		sd_c  = sd_s[ST_H];
		sh_c  = sd_c.d_neg ? -$signed({2'b00, h_s}) : $signed({2'b00, h_s});
		son_w = (C_W'(sd_c.sum) + sh_c) >>> 1;
		dau_w = (C_W'(sd_c.sum) - sh_c) >>> 1;
		sat_c = 1'b0;
		if (son_w > C_MAX) begin
			son_c = C_MAX[GENE_W-1:0];
			sat_c = 1'b1;
		end else if (son_w < C_MIN) begin
			son_c = C_MIN[GENE_W-1:0];
			sat_c = 1'b1;
		end else begin
			son_c = son_w[GENE_W-1:0];
		end
		if (dau_w > C_MAX) begin
			dau_c = C_MAX[GENE_W-1:0];
			sat_c = 1'b1;
		end else if (dau_w < C_MIN) begin
			dau_c = C_MIN[GENE_W-1:0];
			sat_c = 1'b1;
		end else begin
			dau_c = dau_w[GENE_W-1:0];
		end
	end

	// Output register with one skid word
	logic signed [GENE_W-1:0] son_skid_q, dau_skid_q;
	logic                     sat_skid_q, last_skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_q    <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_q) begin
				out_valid <= 1'b1;
				skid_q    <= 1'b0;
			end else begin
				out_valid <= vld_s[ST_H];
			end
		end else if (en && vld_s[ST_H]) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			if (skid_q) begin
				son_gene        <= son_skid_q;
				daughter_gene   <= dau_skid_q;
				child_saturated <= sat_skid_q;
				last_out        <= last_skid_q;
			end else begin
				son_gene        <= son_c;
				daughter_gene   <= dau_c;
				child_saturated <= sat_c;
				last_out        <= sd_c.last;
			end
		end else if (en) begin
			son_skid_q  <= son_c;
			dau_skid_q  <= dau_c;
			sat_skid_q  <= sat_c;
			last_skid_q <= sd_c.last;
		end
	end

`ifndef SYNTH
	// A word in the skid stage always has a word ahead of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_valid)
		else $error("skid word without output word");

	// Normalised log mantissa sits in [1,2)
	a_mt_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] && !sd_s[3].zero |-> lg_mt_s[0][MT_W-1])
		else $error("log mantissa not normalised");

	// Rounded product never exceeds its hold level
	a_h_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_H] |-> h_s <= H_MAX)
		else $error("product above hold level");

	// A full skid stage freezes the pipe, so its last word stays valid
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && vld_s[ST_H] |=> vld_s[ST_H])
		else $error("pipe word lost during stall");
`endif

endmodule
